/* design/dec_pkg.sv */
// shared types, constants and helpers of the descriptor endian converter
`timescale 1ns / 1ps
package dec_pkg;

	localparam int BYTE_W       = 8;
	localparam int GROUP_BYTES  = 4;
	localparam int HOLD_BYTES   = 3;
	localparam int FILL_W       = 2;
	localparam int TYPE_W       = 3;
	localparam int ECOUNT_W     = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 27;
	localparam int DEF_ENTRIES  = 6;
	localparam int DEF_COUNT_BITS = 16;
	localparam int DEF_QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0     = 3'd2;

	// element types
	localparam logic [TYPE_W-1:0] TYPE_INT    = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_SHORT  = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_CHAR   = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_FLOAT  = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 3'd4;

	// group sizes in bytes
	localparam logic [2:0] INT_BYTES   = 3'd4;
	localparam logic [2:0] SHORT_BYTES = 3'd2;

	typedef struct packed {
		logic [GROUP_BYTES-1:0][BYTE_W-1:0] data;
		logic [FILL_W-1:0]                  last_pos;
		logic                               last;
	} group_t;

	// log2 of the element size
	function automatic logic [1:0] elem_shift(input logic [TYPE_W-1:0] typ);
		logic [1:0] s;
		unique case (typ)
			TYPE_INT:    s = 2'd2;
			TYPE_SHORT:  s = 2'd1;
			TYPE_CHAR:   s = 2'd0;
			TYPE_FLOAT:  s = 2'd2;
			TYPE_DOUBLE: s = 2'd3;
			default:     s = 2'd0;
		endcase
		return s;
	endfunction

endpackage

/* design/dec_stream_if.sv */
// input byte channel
`timescale 1ns / 1ps
interface dec_stream_if;
	logic                      valid;
	logic                      ready;
	logic [dec_pkg::BYTE_W-1:0] data_byte;
	logic                      last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/dec_result_if.sv */
// output byte channel
`timescale 1ns / 1ps
interface dec_result_if;
	logic                      valid;
	logic                      ready;
	logic [dec_pkg::BYTE_W-1:0] out_byte;
	logic                      out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

/* design/dec_cfg_if.sv */
// register write channel
`timescale 1ns / 1ps
interface dec_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dec_pkg::CFG_IDX_W-1:0]  index;
	logic [dec_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/descriptor_endian_converter.sv */
// top level of the descriptor driven byte order converter
//
// stream carries the input bytes of a buffer, last_byte marks its end.
// result carries the converted bytes; out_last marks the final byte of
// the buffer. cfg writes the registers: swap mode, entry count and the
// descriptor entries (type above the count field, count below); cfg is
// always ready; the user must write it only while the block is idle (unchecked).
// the front end takes one byte per cycle while the group queue has room
// and turns it into a group of zero to four output bytes (an int or short
// being swapped is held until its last byte). the back end sends one byte
// per cycle while the receiver is ready, so an int group occupies it for
// all four of its bytes and the average stays at one byte per cycle.
// a byte that releases a group is written into the group queue, then
// loaded into the back end's group register once it is free; result reads from it.
// reset clears the descriptor walk, the held group, the queue and the
// output; swap mode resets to 1, all other registers to 0.
// when the receiver stalls, the back end holds its byte, the queue fills
// and stream.ready drops once QUEUE_DEPTH groups are waiting.
`timescale 1ns / 1ps
module descriptor_endian_converter #(
	parameter int ENTRIES     = dec_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS  = dec_pkg::DEF_COUNT_BITS,
	parameter int QUEUE_DEPTH = dec_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	dec_stream_if.sink    stream,
	dec_result_if.source  result,
	dec_cfg_if.sink       cfg
);

	localparam int ENTRY_W = COUNT_BITS + dec_pkg::TYPE_W;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

	logic                             swap_mode_q;
	logic [dec_pkg::ECOUNT_W-1:0]     entry_count_q;
	logic [ENTRIES-1:0][ENTRY_W-1:0]  entry_q;

	dec_pkg::group_t  push_grp;
	logic             push_valid;
	logic             push_ready;
	dec_pkg::group_t  pop_grp;
	logic             pop_valid;
	logic             pop;
	logic [CNT_W-1:0] q_count;
	logic             cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_mode_q <= 1'b1;
			entry_count_q <= '0;
			entry_q <= '0;
		end else if (cfg_fire) begin
			if (cfg.index == dec_pkg::REG_SWAP_MODE) begin
				swap_mode_q <= cfg.data[0];
			end
			if (cfg.index == dec_pkg::REG_ENTRY_COUNT) begin
				entry_count_q <= cfg.data[dec_pkg::ECOUNT_W-1:0];
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (cfg.index == dec_pkg::CFG_IDX_W'(int'(dec_pkg::REG_ENTRY_0) + i)) begin
					entry_q[i] <= cfg.data[ENTRY_W-1:0];
				end
			end
		end
	end

	dec_front #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (stream),
		.swap_mode   (swap_mode_q),
		.entry_count (entry_count_q),
		.entries     (entry_q),
		.grp         (push_grp),
		.grp_valid   (push_valid),
		.grp_ready   (push_ready)
	);

	dec_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (push_grp),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_data  (pop_grp),
		.rd_valid (pop_valid),
		.rd_pop   (pop),
		.count    (q_count)
	);

	dec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_data  (pop_grp),
		.rd_valid (pop_valid),
		.rd_pop   (pop),
		.result   (result)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(QUEUE_DEPTH))
		else $error("group queue count above depth");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.ready && stream.last_byte) |-> push_valid)
		else $error("buffer end produced no group");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready && !(pop && pop_valid)) |=>
		q_count == $past(q_count) + 1'b1)
		else $error("queue count missed a push");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.out_last) |=>
		!(result.valid && result.out_last && !$past(pop_valid)))
		else $error("end of buffer repeated");

endmodule

/* design/dec_front.sv */
// front end: descriptor walk, grouping and byte ordering of each input byte
`timescale 1ns / 1ps
module dec_front #(
	parameter int ENTRIES    = dec_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS = dec_pkg::DEF_COUNT_BITS,
	localparam int ENTRY_W   = COUNT_BITS + dec_pkg::TYPE_W,
	localparam int BL_W      = COUNT_BITS + 3,
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	dec_stream_if.sink                            stream,
	input  logic                                  swap_mode,
	input  logic [dec_pkg::ECOUNT_W-1:0]          entry_count,
	input  logic [ENTRIES-1:0][ENTRY_W-1:0]       entries,
	output dec_pkg::group_t                       grp,
	output logic                                  grp_valid,
	input  logic                                  grp_ready
);

	logic [IDX_W-1:0]                    entry_idx_q;
	logic [BL_W-1:0]                     left_q;
	logic [dec_pkg::TYPE_W-1:0]          type_q;
	logic [dec_pkg::FILL_W-1:0]          fill_q;
	logic [dec_pkg::BYTE_W-1:0]          hold_q [dec_pkg::HOLD_BYTES];

	logic                                fire;
	logic [dec_pkg::ECOUNT_W-1:0]        n_eff;
	logic [ENTRIES-1:0]                  usable;
	logic [IDX_W-1:0]                    start;
	logic                                found;
	logic [IDX_W-1:0]                    f_idx;
	logic [dec_pkg::ECOUNT_W:0]          sum;
	logic [dec_pkg::ECOUNT_W:0]          nxt;
	logic                                need_load;
	logic                                have;
	logic [dec_pkg::TYPE_W-1:0]          cur_type;
	logic [COUNT_BITS-1:0]               f_cnt;
	logic [BL_W-1:0]                     left_dec;
	logic [IDX_W-1:0]                    idx_next;
	logic [2:0]                          gsize;
	logic [2:0]                          fill_inc;
	logic                                swapped;
	logic                                complete;
	logic                                cut;
	logic                                hold;

	assign stream.ready = grp_ready;
	assign fire = stream.valid & grp_ready;

	always_comb begin
		n_eff = (entry_count > dec_pkg::ECOUNT_W'(ENTRIES)) ?
			dec_pkg::ECOUNT_W'(ENTRIES) : entry_count;
		for (int i = 0; i < ENTRIES; i++) begin
			usable[i] = (entries[i][ENTRY_W-1:COUNT_BITS] <= dec_pkg::TYPE_DOUBLE) &&
				(entries[i][COUNT_BITS-1:0] != '0);
		end
		start = ((dec_pkg::ECOUNT_W+1)'(entry_idx_q) >= {1'b0, n_eff}) ? '0 : entry_idx_q;
		found = 1'b0;
		f_idx = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			sum = (dec_pkg::ECOUNT_W+1)'(start) + (dec_pkg::ECOUNT_W+1)'(k);
			if (sum >= {1'b0, n_eff}) begin
				sum = sum - {1'b0, n_eff};
			end
			if (!found && ((dec_pkg::ECOUNT_W+1)'(k) < {1'b0, n_eff}) &&
			    usable[sum[IDX_W-1:0]]) begin
				found = 1'b1;
				f_idx = sum[IDX_W-1:0];
			end
		end
		nxt = (dec_pkg::ECOUNT_W+1)'(f_idx) + 1'b1;
		need_load = (left_q == '0);
		have = !need_load || found;
		cur_type = need_load ? entries[f_idx][ENTRY_W-1:COUNT_BITS] : type_q;
		f_cnt = entries[f_idx][COUNT_BITS-1:0];
		left_dec = (need_load ? (BL_W'(f_cnt) << dec_pkg::elem_shift(cur_type)) : left_q)
			- 1'b1;
		if (need_load && (n_eff != '0)) begin
			if (found) begin
				idx_next = (nxt >= {1'b0, n_eff}) ? '0 : nxt[IDX_W-1:0];
			end else begin
				idx_next = start;
			end
		end else begin
			idx_next = entry_idx_q;
		end

		gsize = 3'd0;
		if (have && swap_mode) begin
			if (cur_type == dec_pkg::TYPE_INT) gsize = dec_pkg::INT_BYTES;
			else if (cur_type == dec_pkg::TYPE_SHORT) gsize = dec_pkg::SHORT_BYTES;
		end
		fill_inc = {1'b0, fill_q} + 3'd1;
		swapped  = (gsize != 3'd0) && ({1'b0, fill_q} < gsize);
		complete = swapped && (fill_inc == gsize);
		cut      = swapped && !complete && (stream.last_byte || (left_dec == '0));
		hold     = swapped && !complete && !cut;

		grp.data = '0;
		if (complete) begin
			grp.data[0] = stream.data_byte;
			for (int j = 1; j < dec_pkg::GROUP_BYTES; j++) begin
				if (j <= int'(fill_q)) begin
					grp.data[j] = hold_q[int'(fill_q) - j];
				end
			end
		end else begin
			for (int j = 0; j < dec_pkg::GROUP_BYTES; j++) begin
				if (j < int'(fill_q) && j < dec_pkg::HOLD_BYTES) begin
					grp.data[j] = hold_q[j];
				end else if (j == int'(fill_q)) begin
					grp.data[j] = stream.data_byte;
				end
			end
		end
		grp.last_pos = fill_q;
		grp.last = stream.last_byte;
		grp_valid = fire && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_idx_q <= '0;
			left_q <= '0;
			type_q <= dec_pkg::TYPE_INT;
			fill_q <= '0;
		end else if (fire) begin
			if (stream.last_byte) begin
				entry_idx_q <= '0;
				left_q <= '0;
				type_q <= dec_pkg::TYPE_INT;
				fill_q <= '0;
			end else begin
				entry_idx_q <= idx_next;
				if (have) begin
					left_q <= left_dec;
					type_q <= cur_type;
				end
				fill_q <= hold ? fill_inc[dec_pkg::FILL_W-1:0] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hold) begin
			hold_q[fill_q] <= stream.data_byte;
		end
	end

endmodule

/* design/dec_fifo.sv */
// short queue of byte groups between front and back end
`timescale 1ns / 1ps
module dec_fifo #(
	parameter int DEPTH = dec_pkg::DEF_QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dec_pkg::group_t wr_data,
	input  logic            wr_valid,
	output logic            wr_ready,
	output dec_pkg::group_t rd_data,
	output logic            rd_valid,
	input  logic            rd_pop,
	output logic [CNT_W-1:0] count
);

	dec_pkg::group_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign count    = count_q;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* design/dec_back.sv */
// back end: serializes one byte group per transaction sequence
`timescale 1ns / 1ps
module dec_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dec_pkg::group_t rd_data,
	input  logic            rd_valid,
	output logic            rd_pop,
	dec_result_if.source    result
);

	dec_pkg::group_t            cur_q;
	logic                       cur_valid_q;
	logic [dec_pkg::FILL_W-1:0] pos_q;
	logic                       fire;
	logic                       done;

	assign result.valid    = cur_valid_q;
	assign result.out_byte = cur_q.data[pos_q];
	assign result.out_last = cur_q.last && (pos_q == cur_q.last_pos);
	assign fire = cur_valid_q && result.ready;
	assign done = fire && (pos_q == cur_q.last_pos);
	assign rd_pop = rd_valid && (!cur_valid_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q <= '0;
		end else if (rd_pop) begin
			cur_valid_q <= 1'b1;
			pos_q <= '0;
		end else if (done) begin
			cur_valid_q <= 1'b0;
			pos_q <= '0;
		end else if (fire) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pop) begin
			cur_q <= rd_data;
		end
	end

endmodule

/* dv/descriptor_endian_converter_tb.sv */
// self-checking testbench of the descriptor endian converter with its own byte order predictor
`timescale 1ns / 1ps
module descriptor_endian_converter_tb;
	import dec_pkg::*;

	localparam int ENTRY_W      = TYPE_W + DEF_COUNT_BITS;
	localparam int IDLE_PCT     = 28;
	localparam int DRAIN        = 16;
	localparam int RANDOM_BYTES = 190;
	localparam logic [TYPE_W-1:0] TYPE_BAD_LOW  = 3'd5;
	localparam logic [TYPE_W-1:0] TYPE_BAD_HIGH = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} stream_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} conv_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	dec_stream_if stream_ch ();
	dec_result_if result_ch ();
	dec_cfg_if    cfg_ch ();

	descriptor_endian_converter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stream_item_t source_q[$];
	conv_byte_t   converted_q[$];
	int unsigned  n_queued;
	int unsigned  n_taken;
	int unsigned  failures;
	bit           quiet;

	// register shadow
	logic                swap_on;
	logic [ECOUNT_W-1:0] used_entries;
	logic [ENTRY_W-1:0]  entry_regs[DEF_ENTRIES];

	// descriptor walk
	logic [BYTE_W-1:0] held[HOLD_BYTES];
	int unsigned       held_cnt;
	int unsigned       walk_idx;
	int unsigned       entry_left;
	logic [TYPE_W-1:0] walk_type;

	function automatic int unsigned element_bytes(input logic [TYPE_W-1:0] t);
		case (t)
			TYPE_INT:    return INT_BYTES;
			TYPE_SHORT:  return SHORT_BYTES;
			TYPE_CHAR:   return 1;
			TYPE_FLOAT:  return INT_BYTES;
			TYPE_DOUBLE: return 2 * INT_BYTES;
			default:     return 0;
		endcase
	endfunction

	// load the next entry with a nonzero byte count
	function automatic bit next_entry();
		int unsigned n;
		int unsigned idx;
		int unsigned len;
		logic [TYPE_W-1:0] t;
		n = (used_entries > DEF_ENTRIES) ? DEF_ENTRIES : used_entries;
		if (n == 0)
			return 1'b0;
		if (walk_idx >= n)
			walk_idx = 0;
		for (int k = 0; k < n; k++) begin
			idx = (walk_idx + k) % n;
			t = entry_regs[idx][ENTRY_W-1 -: TYPE_W];
			len = entry_regs[idx][DEF_COUNT_BITS-1:0] * element_bytes(t);
			if (len != 0) begin
				entry_left = len;
				walk_type = t;
				walk_idx = (idx + 1) % n;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic convert_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [BYTE_W-1:0] outb[GROUP_BYTES];
		int unsigned n;
		int unsigned gsize;
		bit have;
		n = 0;
		gsize = 0;
		have = 1'b1;
		if (entry_left == 0)
			have = next_entry();
		if (have) begin
			entry_left--;
			if (swap_on) begin
				if (walk_type == TYPE_INT)
					gsize = INT_BYTES;
				else if (walk_type == TYPE_SHORT)
					gsize = SHORT_BYTES;
			end
		end
		if (gsize != 0 && held_cnt < gsize) begin
			if (held_cnt + 1 == gsize) begin
				outb[n++] = b;
				for (int i = held_cnt; i > 0; i--)
					outb[n++] = held[i-1];
				held_cnt = 0;
			end else if (last || entry_left == 0) begin
				// group cut short: arrival order
				for (int i = 0; i < held_cnt; i++)
					outb[n++] = held[i];
				outb[n++] = b;
				held_cnt = 0;
			end else begin
				held[held_cnt] = b;
				held_cnt++;
			end
		end else begin
			for (int i = 0; i < held_cnt; i++)
				outb[n++] = held[i];
			held_cnt = 0;
			outb[n++] = b;
		end
		for (int k = 0; k < n; k++)
			converted_q.push_back({outb[k], last && (k == n - 1)});
		if (last) begin
			held_cnt = 0;
			walk_idx = 0;
			entry_left = 0;
			walk_type = TYPE_INT;
		end
	endtask

	// driver
	always @(posedge clk) begin
		stream_item_t nxt;
		if (!arst_n) begin
			stream_ch.valid <= 1'b0;
		end else begin
			if (stream_ch.valid && stream_ch.ready) begin
				convert_byte(stream_ch.data_byte, stream_ch.last_byte);
				n_taken++;
			end
			if (!stream_ch.valid || stream_ch.ready) begin
				if (source_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = source_q.pop_front();
					stream_ch.valid <= 1'b1;
					stream_ch.data_byte <= nxt.data;
					stream_ch.last_byte <= nxt.last;
				end else begin
					stream_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		conv_byte_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (converted_q.size() == 0) begin
					$error("out_byte: expected none, got %h", result_ch.out_byte);
					failures++;
				end else begin
					want = converted_q.pop_front();
					if (result_ch.out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, result_ch.out_byte);
						failures++;
					end
					if (result_ch.out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, result_ch.out_last);
						failures++;
					end
				end
			end
			result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send(input logic [BYTE_W-1:0] b, input logic last);
		source_q.push_back({b, last});
		n_queued++;
	endtask

	// valid stays high across a batch; end_writes lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == REG_SWAP_MODE)
			swap_on = val[0];
		else if (idx == REG_ENTRY_COUNT)
			used_entries = val[ECOUNT_W-1:0];
		else
			entry_regs[idx - REG_ENTRY_0] = val[ENTRY_W-1:0];
	endtask

	task automatic end_writes();
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] entry_word(input logic [TYPE_W-1:0] t,
			input int unsigned cnt);
		logic [DEF_COUNT_BITS-1:0] c;
		c = DEF_COUNT_BITS'(cnt);
		return CFG_DATA_W'({t, c});
	endfunction

	task automatic write_entry(input int k, input logic [CFG_DATA_W-1:0] val);
		write_reg(CFG_IDX_W'(REG_ENTRY_0 + k), val);
	endtask

	task automatic settle();
		while (n_taken != n_queued || converted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic randomize_regs(input bit all);
		int unsigned r;
		logic [TYPE_W-1:0] t;
		int unsigned cnt;
		if (all || $urandom_range(1))
			write_reg(REG_SWAP_MODE, CFG_DATA_W'($urandom_range(1)));
		if (all || $urandom_range(1)) begin
			r = $urandom_range(9);
			write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(r == 0 ? 0 : r == 1 ? 7 : $urandom_range(1, 6)));
		end
		for (int k = 0; k < DEF_ENTRIES; k++) begin
			if (all || $urandom_range(1)) begin
				t = ($urandom_range(9) < 9) ? TYPE_W'($urandom_range(0, 4))
					: TYPE_W'($urandom_range(5, 7));
				r = $urandom_range(19);
				cnt = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : (r == 2) ? $urandom_range(0, 65535)
					: $urandom_range(1, 4);
				write_entry(k, entry_word(t, cnt));
			end
		end
		end_writes();
	endtask

	initial begin
		int unsigned random_sent;
		int unsigned phase;
		int unsigned len;
		bit cut;
		bit tail;
		arst_n = 1'b0;
		stream_ch.valid = 1'b0;
		stream_ch.data_byte = '0;
		stream_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		n_queued = 0;
		n_taken = 0;
		failures = 0;
		quiet = 1'b0;
		swap_on = 1'b1;
		used_entries = '0;
		foreach (entry_regs[k])
			entry_regs[k] = '0;
		held_cnt = 0;
		walk_idx = 0;
		entry_left = 0;
		walk_type = TYPE_INT;
		random_sent = 0;
		phase = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty descriptor after reset
		send(8'hFF, 1'b1);
		settle();

		// every type, skipped entries, count above the entry limit, group cut by buffer end
		write_reg(REG_SWAP_MODE, CFG_DATA_W'(1));
		write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(7));
		write_entry(0, entry_word(TYPE_INT, 1));
		write_entry(1, entry_word(TYPE_SHORT, 1));
		write_entry(2, entry_word(TYPE_CHAR, 0));
		write_entry(3, CFG_DATA_W'({ENTRY_W{1'b1}}));
		write_entry(4, entry_word(TYPE_FLOAT, 1));
		write_entry(5, entry_word(TYPE_DOUBLE, 1));
		end_writes();
		for (int i = 0; i < 21; i++)
			send(8'(i == 0 ? 8'h00 : i == 1 ? 8'hFF : $urandom_range(255)), i == 20);
		settle();

		// swap cleared in the middle of an int
		write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(1));
		write_entry(0, entry_word(TYPE_INT, 2));
		end_writes();
		send(8'hA5, 1'b0);
		send(8'h5A, 1'b0);
		settle();
		write_reg(REG_SWAP_MODE, CFG_DATA_W'(0));
		end_writes();
		send(8'h3C, 1'b0);
		send(8'hC3, 1'b1);
		settle();

		// no usable entry
		write_reg(REG_SWAP_MODE, CFG_DATA_W'(1));
		write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(2));
		write_entry(0, entry_word(TYPE_CHAR, 0));
		write_entry(1, entry_word(TYPE_BAD_LOW, 9));
		end_writes();
		send(8'h81, 1'b1);
		settle();

		while (random_sent < RANDOM_BYTES) begin
			randomize_regs(phase == 0);
			quiet = (phase == 4);
			len = quiet ? 48 : $urandom_range(1, 16);
			cut = !quiet && ($urandom_range(7) == 0);
			for (int i = 0; i < len; i++) begin
				tail = (i == len - 1) && !cut;
				send(8'($urandom_range(255)), tail || ($urandom_range(15) == 0));
			end
			random_sent += len;
			settle();
			quiet = 1'b0;
			phase++;
		end

		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule
